// ----- src/wdwr_pkg.sv -----
// Shared types and constants for the weighted draw without replacement block.
package wdwr_pkg;

  // Width of the slot field and of the index fields in the result
  localparam int unsigned SLOT_W    = 4;
  localparam int unsigned OUT_IDX_W = 4;

  // Input kinds carried on tuser
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_DRAW = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MUL,
    ST_ADD,
    ST_SCAN,
    ST_FIN
  } state_e;

  // Controls for the threshold unit
  typedef struct packed {
    logic mul_en;
    logic add_en;
  } tgt_ctrl_t;

endpackage

// ----- src/weighted_draw_without_replacement.sv -----
// Top level: weighted draw without replacement over a RAM-held weight table.
// A load transfer (tuser = 0) writes one weight into the table, clears the
// drawn set and restarts the ranking; it reads the old weight and then writes
// the new one, so that the running totals of all weights and of the undrawn
// weights stay exact. A draw transfer (tuser = 1) is accepted, forms the
// threshold u * T from the kept undrawn total in the multiply and add states,
// then makes one weight RAM read per item through the single read port while
// the running sum is compared, and posts the result once the output register
// is free. The picked index, its ranking position and, on tlast, the end of
// the ranking go to an output register, so the next transfer is taken while
// a result waits on the master side. Loads produce no result.
module weighted_draw_without_replacement
  import wdwr_pkg::*;
#(
  parameter int unsigned ITEMS       = 16,
  parameter int unsigned WEIGHT_BITS = 16,
  parameter int unsigned RANDOM_BITS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // tdata: slot, weight_value, random_fraction (lowest bit up), zero padded
  input  logic [((SLOT_W+WEIGHT_BITS+RANDOM_BITS+7)/8)*8-1:0] s_axis_tdata,
  // tuser: mode
  input  logic s_axis_tuser,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // tdata: drawn_item, rank_position (lowest bit up)
  output logic [2*OUT_IDX_W-1:0] m_axis_tdata,
  // tlast: ranking_done
  output logic m_axis_tlast
);

  localparam int unsigned IDX_W  = $clog2(ITEMS);
  localparam int unsigned CNT_W  = $clog2(ITEMS + 1);
  localparam int unsigned TOT_W  = WEIGHT_BITS + IDX_W;
  localparam int unsigned PROD_W = TOT_W + RANDOM_BITS;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ITEMS - 1);

  state_e state_q, state_d;

  // input field split
  logic [SLOT_W-1:0]      in_slot;
  logic [WEIGHT_BITS-1:0] in_weight;
  logic [RANDOM_BITS-1:0] in_rand;
  logic                   in_fire;
  logic [IDX_W+SLOT_W-1:0] slot_ext;
  logic [IDX_W-1:0]       in_slot_idx;
  logic                   in_range;

  assign in_slot   = s_axis_tdata[SLOT_W-1:0];
  assign in_weight = s_axis_tdata[SLOT_W+WEIGHT_BITS-1:SLOT_W];
  assign in_rand   = s_axis_tdata[SLOT_W+WEIGHT_BITS+RANDOM_BITS-1:SLOT_W+WEIGHT_BITS];
  assign in_fire   = s_axis_tvalid && s_axis_tready;
  assign slot_ext    = {{IDX_W{1'b0}}, in_slot};
  assign in_slot_idx = slot_ext[IDX_W-1:0];
  assign in_range    = (slot_ext < (IDX_W+SLOT_W)'(ITEMS));

  // captured transfer
  logic [IDX_W-1:0]       slot_q;
  logic                   range_q;
  logic [WEIGHT_BITS-1:0] wval_q;
  logic [RANDOM_BITS-1:0] u_q;

  // control state
  logic [ITEMS-1:0] ent_valid_q, drawn_q;
  logic [IDX_W-1:0] pos_q;
  logic [TOT_W-1:0] sum_all_q, sum_und_q;
  logic [CNT_W-1:0] cnt_q;
  logic             v1_q;
  logic [IDX_W-1:0] a1_q;

  // scan state
  logic [TOT_W-1:0]       run_q;
  logic                   found_q;
  logic [IDX_W-1:0]       pick_q, last_q;
  logic [WEIGHT_BITS-1:0] pick_w_q, last_w_q;

  // output register
  logic                 out_valid_q;
  logic [OUT_IDX_W-1:0] out_item_q, out_pos_q;
  logic                 out_done_q;

  // RAM and threshold unit
  logic                   ram_we;
  logic [IDX_W-1:0]       ram_raddr;
  logic [WEIGHT_BITS-1:0] ram_rdata;
  logic                   rd_issue;
  tgt_ctrl_t              tgt_ctrl;
  logic [PROD_W-1:0]      target;

  wdwr_weight_ram #(
    .DEPTH (ITEMS),
    .WIDTH (WEIGHT_BITS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (slot_q),
    .wdata_i (wval_q),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  wdwr_target #(
    .TOT_W (TOT_W),
    .RND_W (RANDOM_BITS)
  ) u_target (
    .clk_i    (clk_i),
    .ctrl_i   (tgt_ctrl),
    .u_i      (u_q),
    .total_i  (sum_und_q),
    .target_o (target)
  );

  // scan step on the weight that just came out of the RAM
  logic [WEIGHT_BITS-1:0] w1;
  logic                   undrawn1;
  logic [TOT_W-1:0]       run_next;
  logic                   hit;
  logic                   scan_take;

  assign w1        = ent_valid_q[a1_q] ? ram_rdata : '0;
  assign undrawn1  = !drawn_q[a1_q];
  assign run_next  = run_q + TOT_W'(w1);
  assign hit       = ({run_next, {RANDOM_BITS{1'b0}}} >= target);
  assign scan_take = v1_q && undrawn1 && (state_q == ST_SCAN);

  // old weight for the load update; unwritten entries read as zero
  logic [WEIGHT_BITS-1:0] old_w;
  logic [TOT_W-1:0]       sum_all_new;
  assign old_w       = ent_valid_q[slot_q] ? ram_rdata : '0;
  assign sum_all_new = sum_all_q - TOT_W'(old_w) + TOT_W'(wval_q);

  // result of the draw
  logic [IDX_W-1:0]       fin_idx;
  logic [WEIGHT_BITS-1:0] fin_w;
  logic                   fin_done;
  logic                   fin_go;
  logic [IDX_W+OUT_IDX_W-1:0] item_ext, pos_ext;

  assign fin_idx  = found_q ? pick_q : last_q;
  assign fin_w    = found_q ? pick_w_q : last_w_q;
  assign fin_done = (pos_q == LAST_IDX);
  assign fin_go   = (state_q == ST_FIN) && (!out_valid_q || m_axis_tready);
  assign item_ext = {{OUT_IDX_W{1'b0}}, fin_idx};
  assign pos_ext  = {{OUT_IDX_W{1'b0}}, pos_q};

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = (s_axis_tuser == MODE_LOAD) ? ST_LOAD : ST_MUL;
        end
      end
      ST_LOAD: state_d = ST_IDLE;
      ST_MUL:  state_d = ST_ADD;
      ST_ADD:  state_d = ST_SCAN;
      ST_SCAN: begin
        if (v1_q && (a1_q == LAST_IDX)) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (fin_go) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs of the controller
  always_comb begin
    s_axis_tready   = 1'b0;
    ram_we          = 1'b0;
    ram_raddr       = in_slot_idx;
    rd_issue        = 1'b0;
    tgt_ctrl.mul_en = 1'b0;
    tgt_ctrl.add_en = 1'b0;
    case (state_q)
      ST_IDLE: s_axis_tready = 1'b1;
      ST_LOAD: ram_we = range_q;
      ST_MUL:  tgt_ctrl.mul_en = 1'b1;
      ST_ADD: begin
        tgt_ctrl.add_en = 1'b1;
        ram_raddr       = '0;
        rd_issue        = 1'b1;
      end
      ST_SCAN: begin
        ram_raddr = cnt_q[IDX_W-1:0];
        rd_issue  = (cnt_q < CNT_W'(ITEMS));
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ent_valid_q <= '0;
      drawn_q     <= '0;
      pos_q       <= '0;
      sum_all_q   <= '0;
      sum_und_q   <= '0;
      cnt_q       <= '0;
      v1_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      v1_q    <= rd_issue;

      if (state_q == ST_ADD) begin
        cnt_q <= CNT_W'(1);
      end else if (state_q == ST_SCAN && rd_issue) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end

      if (state_q == ST_LOAD) begin
        drawn_q <= '0;
        pos_q   <= '0;
        if (range_q) begin
          ent_valid_q[slot_q] <= 1'b1;
          sum_all_q           <= sum_all_new;
          sum_und_q           <= sum_all_new;
        end else begin
          sum_und_q <= sum_all_q;
        end
      end

      if (fin_go) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (fin_go) begin
        if (fin_done) begin
          drawn_q   <= '0;
          pos_q     <= '0;
          sum_und_q <= sum_all_q;
        end else begin
          drawn_q[fin_idx] <= 1'b1;
          pos_q            <= pos_q + IDX_W'(1);
          sum_und_q        <= sum_und_q - TOT_W'(fin_w);
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    a1_q <= ram_raddr;
    if (in_fire) begin
      slot_q  <= in_slot_idx;
      range_q <= in_range;
      wval_q  <= in_weight;
      u_q     <= in_rand;
    end
    if (state_q == ST_MUL) begin
      run_q   <= '0;
      found_q <= 1'b0;
    end
    if (scan_take) begin
      run_q    <= run_next;
      last_q   <= a1_q;
      last_w_q <= w1;
      if (!found_q && hit) begin
        found_q  <= 1'b1;
        pick_q   <= a1_q;
        pick_w_q <= w1;
      end
    end
    if (fin_go) begin
      out_item_q <= item_ext[OUT_IDX_W-1:0];
      out_pos_q  <= pos_ext[OUT_IDX_W-1:0];
      out_done_q <= fin_done;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_pos_q, out_item_q};
  assign m_axis_tlast  = out_done_q;

endmodule

// ----- src/wdwr_weight_ram.sv -----
// Weight table: synchronous RAM, one write and one registered read port.
module wdwr_weight_ram #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/wdwr_target.sv -----
// Threshold unit: u * T built from two registered partial products, then summed.
module wdwr_target
  import wdwr_pkg::*;
#(
  parameter int unsigned TOT_W = 20,
  parameter int unsigned RND_W = 16
) (
  input  logic                   clk_i,
  input  tgt_ctrl_t              ctrl_i,
  input  logic [RND_W-1:0]       u_i,
  input  logic [TOT_W-1:0]       total_i,
  output logic [TOT_W+RND_W-1:0] target_o
);

  localparam int unsigned HALF   = (TOT_W + 1) / 2;
  localparam int unsigned HI_W   = TOT_W - HALF;
  localparam int unsigned PROD_W = TOT_W + RND_W;

  logic [RND_W+HALF-1:0] plo_q, plo_d;
  logic [RND_W+HI_W-1:0] phi_q, phi_d;
  logic [PROD_W-1:0]     target_q, target_d;

  always_comb begin
    plo_d    = (RND_W+HALF)'(u_i) * (RND_W+HALF)'(total_i[HALF-1:0]);
    phi_d    = (RND_W+HI_W)'(u_i) * (RND_W+HI_W)'(total_i[TOT_W-1:HALF]);
    target_d = {{HI_W{1'b0}}, plo_q} + {phi_q, {HALF{1'b0}}};
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      plo_q <= plo_d;
      phi_q <= phi_d;
    end
    if (ctrl_i.add_en) begin
      target_q <= target_d;
    end
  end

  assign target_o = target_q;

endmodule

// ----- tb/sv/weighted_draw_without_replacement_test.sv -----
// Self-checking stream testbench for the weighted draw without replacement block.
module weighted_draw_without_replacement_test;
  import wdwr_pkg::*;

  localparam int unsigned ITEMS       = 16;
  localparam int unsigned WEIGHT_BITS = 16;
  localparam int unsigned RANDOM_BITS = 16;
  localparam int unsigned IN_W        = ((SLOT_W + WEIGHT_BITS + RANDOM_BITS + 7) / 8) * 8;
  localparam int unsigned PAD_W       = IN_W - SLOT_W - WEIGHT_BITS - RANDOM_BITS;
  localparam int unsigned RANDOM_ITEMS = 1800;
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;

  typedef struct packed {
    logic [OUT_IDX_W-1:0] item;
    logic [OUT_IDX_W-1:0] pos;
    logic                 done;
  } draw_res_t;

  typedef struct {
    logic                   mode;
    logic [SLOT_W-1:0]      slot;
    logic [WEIGHT_BITS-1:0] weight;
    logic [RANDOM_BITS-1:0] frac;
    bit                     typed;
    draw_res_t              want;
  } stim_row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [IN_W-1:0]      s_axis_tdata = '0;
  logic                 s_axis_tuser = MODE_LOAD;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [2*OUT_IDX_W-1:0] m_axis_tdata;
  logic                 m_axis_tlast;

  // predictor state
  logic [WEIGHT_BITS-1:0] weights [ITEMS];
  logic [ITEMS-1:0]       drawn_set;
  int unsigned            next_pos;

  draw_res_t   pending_draws [$];
  stim_row_t   directed_rows [$];
  int unsigned fail_count = 0;
  int unsigned items_sent = 0;
  int unsigned cycle_count = 0;
  bit          tx_calm = 1'b0;
  int unsigned rx_hold = 0;
  int unsigned rx_calm = 0;
  int unsigned rx_roll;

  weighted_draw_without_replacement #(
    .ITEMS       (ITEMS),
    .WEIGHT_BITS (WEIGHT_BITS),
    .RANDOM_BITS (RANDOM_BITS)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("weighted_draw_without_replacement: mismatch");
      $finish;
    end
  end

  // Apply one accepted item to the predictor; a draw yields one result.
  function automatic void rank_next(input logic mode, input logic [SLOT_W-1:0] slot,
                                    input logic [WEIGHT_BITS-1:0] w,
                                    input logic [RANDOM_BITS-1:0] u,
                                    output bit has_res, output draw_res_t res);
    logic [63:0] total;
    logic [63:0] run;
    logic [63:0] target;
    int unsigned pick;
    int unsigned last;
    bit          found;
    total = 0;
    run = 0;
    pick = 0;
    last = 0;
    found = 1'b0;
    has_res = 1'b0;
    res = '0;
    if (mode == MODE_LOAD) begin
      if (slot < ITEMS) weights[slot] = w;
      drawn_set = '0;
      next_pos = 0;
      return;
    end
    for (int i = 0; i < ITEMS; i++) begin
      if (!drawn_set[i]) total += 64'(weights[i]);
    end
    target = total * 64'(u);
    for (int i = 0; i < ITEMS; i++) begin
      if (!drawn_set[i]) begin
        run += 64'(weights[i]);
        last = i;
        if (!found && ((run << RANDOM_BITS) >= target)) begin
          pick = i;
          found = 1'b1;
        end
      end
    end
    if (!found) pick = last;
    has_res = 1'b1;
    res.item = pick[OUT_IDX_W-1:0];
    res.pos = next_pos[OUT_IDX_W-1:0];
    if (next_pos + 1 >= ITEMS) begin
      res.done = 1'b1;
      drawn_set = '0;
      next_pos = 0;
    end else begin
      res.done = 1'b0;
      drawn_set[pick] = 1'b1;
      next_pos++;
    end
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [WEIGHT_BITS-1:0] pick_weight();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 20) return '1;
    if (r < 35) return WEIGHT_BITS'($urandom_range(1, 15));
    return WEIGHT_BITS'($urandom);
  endfunction

  function automatic logic [RANDOM_BITS-1:0] pick_frac();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 8) return '0;
    if (r < 16) return '1;
    return RANDOM_BITS'($urandom);
  endfunction

  task automatic dir_row(input logic mode, input logic [SLOT_W-1:0] slot,
                         input logic [WEIGHT_BITS-1:0] w, input logic [RANDOM_BITS-1:0] u,
                         input bit typed, input int unsigned item, input int unsigned pos,
                         input bit done);
    stim_row_t r;
    r.mode = mode;
    r.slot = slot;
    r.weight = w;
    r.frac = u;
    r.typed = typed;
    r.want.item = item[OUT_IDX_W-1:0];
    r.want.pos = pos[OUT_IDX_W-1:0];
    r.want.done = done;
    directed_rows.push_back(r);
  endtask

  // Drive one item, wait for its transfer, then record what it should produce.
  task automatic send_item(input stim_row_t r);
    int unsigned gap;
    bit          has_res;
    draw_res_t   res;
    gap = tx_calm ? 0 : pick_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tuser  <= r.mode;
    s_axis_tdata  <= {{PAD_W{1'b0}}, r.frac, r.weight, r.slot};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    rank_next(r.mode, r.slot, r.weight, r.frac, has_res, res);
    if (has_res) pending_draws.push_back(r.typed ? r.want : res);
    items_sent++;
  endtask

  task automatic random_draw();
    stim_row_t r;
    r.mode = MODE_DRAW;
    r.slot = SLOT_W'($urandom);
    r.weight = WEIGHT_BITS'($urandom);
    r.frac = pick_frac();
    r.typed = 1'b0;
    r.want = '0;
    // occasional load in the middle of a ranking
    if ($urandom_range(0, 19) == 0) begin
      r.mode = MODE_LOAD;
      r.weight = pick_weight();
    end
    send_item(r);
  endtask

  always @(posedge clk_i) begin
    if (rx_calm != 0) begin
      rx_calm--;
      m_axis_tready <= 1'b1;
    end else if (rx_hold != 0) begin
      rx_hold--;
      m_axis_tready <= 1'b0;
    end else begin
      rx_roll = $urandom_range(0, 99);
      if (rx_roll < 2) rx_calm = $urandom_range(50, 300);
      else if (rx_roll < 25) rx_hold = $urandom_range(1, 3);
      else if (rx_roll < 27) rx_hold = $urandom_range(20, 50);
      m_axis_tready <= (rx_hold == 0);
    end
  end

  always @(posedge clk_i) begin : check_results
    draw_res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_draws.size() == 0) begin
        $display("%0t: unexpected result, actual item %0d pos %0d last %0b", $time,
                 m_axis_tdata[OUT_IDX_W-1:0], m_axis_tdata[2*OUT_IDX_W-1:OUT_IDX_W],
                 m_axis_tlast);
        fail_count++;
      end else begin
        want = pending_draws.pop_front();
        if (m_axis_tdata[OUT_IDX_W-1:0] !== want.item) begin
          $display("%0t: drawn_item expected %0d actual %0d", $time, want.item,
                   m_axis_tdata[OUT_IDX_W-1:0]);
          fail_count++;
        end
        if (m_axis_tdata[2*OUT_IDX_W-1:OUT_IDX_W] !== want.pos) begin
          $display("%0t: rank_position expected %0d actual %0d", $time, want.pos,
                   m_axis_tdata[2*OUT_IDX_W-1:OUT_IDX_W]);
          fail_count++;
        end
        if (m_axis_tlast !== want.done) begin
          $display("%0t: ranking_done expected %0b actual %0b", $time, want.done,
                   m_axis_tlast);
          fail_count++;
        end
      end
    end
  end

  initial begin : stimulus
    stim_row_t   r;
    int unsigned nload;
    int unsigned ndraw;
    int unsigned k;
    for (int i = 0; i < ITEMS; i++) weights[i] = '0;
    drawn_set = '0;
    next_pos = 0;

    // zero weights after reset: each draw takes the first undrawn item
    dir_row(MODE_DRAW, 4'h0, 16'h0000, 16'h0000, 1,  0,  0, 0);
    dir_row(MODE_DRAW, 4'hF, 16'hFFFF, 16'hFFFF, 1,  1,  1, 0);
    dir_row(MODE_DRAW, 4'h0, 16'h0000, 16'h0000, 1,  2,  2, 0);
    dir_row(MODE_DRAW, 4'hF, 16'hFFFF, 16'hFFFF, 1,  3,  3, 0);
    dir_row(MODE_DRAW, 4'h0, 16'h0000, 16'h0000, 1,  4,  4, 0);
    dir_row(MODE_DRAW, 4'hF, 16'hFFFF, 16'hFFFF, 1,  5,  5, 0);
    dir_row(MODE_DRAW, 4'h0, 16'h0000, 16'h0000, 1,  6,  6, 0);
    dir_row(MODE_DRAW, 4'hF, 16'hFFFF, 16'hFFFF, 1,  7,  7, 0);
    dir_row(MODE_DRAW, 4'h0, 16'h0000, 16'h0000, 1,  8,  8, 0);
    dir_row(MODE_DRAW, 4'hF, 16'hFFFF, 16'hFFFF, 1,  9,  9, 0);
    dir_row(MODE_DRAW, 4'h0, 16'h0000, 16'h0000, 1, 10, 10, 0);
    dir_row(MODE_DRAW, 4'hF, 16'hFFFF, 16'hFFFF, 1, 11, 11, 0);
    dir_row(MODE_DRAW, 4'h0, 16'h0000, 16'h0000, 1, 12, 12, 0);
    dir_row(MODE_DRAW, 4'hF, 16'hFFFF, 16'hFFFF, 1, 13, 13, 0);
    dir_row(MODE_DRAW, 4'h0, 16'h0000, 16'h0000, 1, 14, 14, 0);
    dir_row(MODE_DRAW, 4'hF, 16'hFFFF, 16'hFFFF, 1, 15, 15, 1);
    // drawn set cleared after the last position
    dir_row(MODE_DRAW, 4'h0, 16'h0000, 16'h8000, 1,  0,  0, 0);
    // one max weight at the top slot
    dir_row(MODE_LOAD, 4'hF, 16'hFFFF, 16'h0000, 0,  0,  0, 0);
    dir_row(MODE_DRAW, 4'h0, 16'h0000, 16'h0000, 1,  0,  0, 0);
    dir_row(MODE_DRAW, 4'h0, 16'h0000, 16'hFFFF, 1, 15,  1, 0);
    dir_row(MODE_LOAD, 4'hA, 16'hAAAA, 16'h5555, 0,  0,  0, 0);
    dir_row(MODE_LOAD, 4'h5, 16'h5555, 16'hAAAA, 0,  0,  0, 0);
    dir_row(MODE_DRAW, 4'h0, 16'h0000, 16'h8000, 0,  0,  0, 0);
    dir_row(MODE_DRAW, 4'hA, 16'hAAAA, 16'h5555, 0,  0,  0, 0);
    dir_row(MODE_DRAW, 4'h5, 16'h5555, 16'hAAAA, 0,  0,  0, 0);

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) send_item(directed_rows[i]);

    // random part: a few weight loads, then a run of draws
    while (items_sent < RANDOM_ITEMS + directed_rows.size()) begin
      tx_calm = ($urandom_range(0, 5) == 0);
      nload = $urandom_range(1, 4);
      repeat (nload) begin
        r.mode = MODE_LOAD;
        r.slot = SLOT_W'($urandom);
        r.weight = pick_weight();
        r.frac = RANDOM_BITS'($urandom);
        r.typed = 1'b0;
        r.want = '0;
        send_item(r);
      end
      k = $urandom_range(0, 9);
      if (k < 6) ndraw = ITEMS;
      else if (k < 8) ndraw = $urandom_range(1, ITEMS - 1);
      else ndraw = $urandom_range(ITEMS + 1, 2 * ITEMS + 8);
      repeat (ndraw) random_draw();
    end
    s_axis_tvalid <= 1'b0;

    while (pending_draws.size() != 0) @(posedge clk_i);
    repeat (ITEMS + 8) @(posedge clk_i);
    if (fail_count == 0 && pending_draws.size() == 0) begin
      $display("weighted_draw_without_replacement: match");
    end else begin
      $display("weighted_draw_without_replacement: mismatch");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/wdwr_pkg.sv
src/wdwr_weight_ram.sv
src/wdwr_target.sv
src/weighted_draw_without_replacement.sv
tb/sv/weighted_draw_without_replacement_test.sv
